// ===== src/thermal_throttle_levels_top_defines.svh =====
// Assertion macros used by the RTL file thermal_throttle_levels_top.sv.
`ifndef THERMAL_THROTTLE_LEVELS_TOP_DEFINES_SVH
`define THERMAL_THROTTLE_LEVELS_TOP_DEFINES_SVH

// Same-cycle check: cons must hold whenever ante holds.
`define TTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define TTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ttl_pkg.sv =====
package ttl_pkg;

   localparam int TEMP_W  = 12;
   localparam int THR_W   = 10;
   localparam int FREQ_W  = 22;
   localparam int LEVEL_W = 2;
   localparam int CSR_IDX_W = 3;

   // readings above this are treated as failed
   localparam logic [TEMP_W-1:0] TEMP_LIMIT = 12'd1000;

   localparam int LOW_CLEAR_TEMP_DEF = 60;

   // register reset values
   localparam logic [THR_W-1:0]  LOW_TRIP_RST   = 10'd64;
   localparam logic [THR_W-1:0]  MID_TRIP_RST   = 10'd69;
   localparam logic [THR_W-1:0]  HIGH_TRIP_RST  = 10'd80;
   localparam logic [THR_W-1:0]  MID_CLEAR_RST  = 10'd65;
   localparam logic [THR_W-1:0]  HIGH_CLEAR_RST = 10'd75;
   localparam logic [FREQ_W-1:0] LOW_CAP_RST    = 22'd1188000;
   localparam logic [FREQ_W-1:0] MID_CAP_RST    = 22'd972000;
   localparam logic [FREQ_W-1:0] HIGH_CAP_RST   = 22'd384000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_TRIP   = 3'd0,
      CSR_MID_TRIP   = 3'd1,
      CSR_HIGH_TRIP  = 3'd2,
      CSR_MID_CLEAR  = 3'd3,
      CSR_HIGH_CLEAR = 3'd4,
      CSR_LOW_CAP    = 3'd5,
      CSR_MID_CAP    = 3'd6,
      CSR_HIGH_CAP   = 3'd7
   } csr_index_type;

   // throttle levels
   typedef enum logic [LEVEL_W-1:0] {
      LVL_NONE = 2'd0,
      LVL_LOW  = 2'd1,
      LVL_MID  = 2'd2,
      LVL_HIGH = 2'd3
   } level_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic              read_ok;
      logic [FREQ_W-1:0] user_max_freq;
   } req_data_type;

   typedef struct packed {
      logic               apply_freq;
      logic [FREQ_W-1:0]  new_max_freq;
      logic [LEVEL_W-1:0] throttle_level;
      logic               sample_rejected;
   } rsp_data_type;

endpackage

// ===== src/thermal_throttle_levels_top.sv =====
// Channel   Ports                          Direction
// request   req_valid req_ready req_data   in
// response  rsp_valid rsp_ready rsp_data   out
// csr       csr_we csr_index csr_wdata     in, write only
//
// One request per cycle while rsp_ready holds; a request passes the request register, then the response register.
// The throttle state updates when a non-rejected request moves into the response register.
// A request is taken while one response waits; both registers full with rsp_ready low stalls req_ready.
// Synchronous active-high reset clears state and valids and loads the CSR reset values; no clearing pass.
`include "thermal_throttle_levels_top_defines.svh"

module thermal_throttle_levels_top #(
   parameter int LOW_CLEAR_TEMP = ttl_pkg::LOW_CLEAR_TEMP_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ttl_pkg::req_data_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ttl_pkg::rsp_data_type                 rsp_data,
   input  logic                                  csr_we,
   input  logic [ttl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ttl_pkg::FREQ_W-1:0]            csr_wdata
);

   localparam logic [ttl_pkg::TEMP_W-1:0] LOW_CLEAR = ttl_pkg::TEMP_W'(LOW_CLEAR_TEMP);

   // configuration registers
   logic [ttl_pkg::THR_W-1:0]  low_trip_ff, mid_trip_ff, high_trip_ff;
   logic [ttl_pkg::THR_W-1:0]  mid_clear_ff, high_clear_ff;
   logic [ttl_pkg::FREQ_W-1:0] low_cap_ff, mid_cap_ff, high_cap_ff;

   // throttle state
   ttl_pkg::level_type         level_ff, level_in;
   logic [ttl_pkg::FREQ_W-1:0] saved_max_ff, saved_max_in;
   logic [ttl_pkg::FREQ_W-1:0] active_cap_ff, active_cap_in;

   // pipeline registers
   logic                  req_valid_ff;
   ttl_pkg::req_data_type req_q_ff;
   logic                  rsp_valid_ff;
   ttl_pkg::rsp_data_type rsp_q_ff, rsp_q_in;

   logic advance;
   logic rejected;
   logic cleared;
   logic [ttl_pkg::TEMP_W-1:0] temp;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_q_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_trip_ff   <= ttl_pkg::LOW_TRIP_RST;
         mid_trip_ff   <= ttl_pkg::MID_TRIP_RST;
         high_trip_ff  <= ttl_pkg::HIGH_TRIP_RST;
         mid_clear_ff  <= ttl_pkg::MID_CLEAR_RST;
         high_clear_ff <= ttl_pkg::HIGH_CLEAR_RST;
         low_cap_ff    <= ttl_pkg::LOW_CAP_RST;
         mid_cap_ff    <= ttl_pkg::MID_CAP_RST;
         high_cap_ff   <= ttl_pkg::HIGH_CAP_RST;
      end else if (csr_we) begin
         case (ttl_pkg::csr_index_type'(csr_index))
            ttl_pkg::CSR_LOW_TRIP:   low_trip_ff   <= csr_wdata[ttl_pkg::THR_W-1:0];
            ttl_pkg::CSR_MID_TRIP:   mid_trip_ff   <= csr_wdata[ttl_pkg::THR_W-1:0];
            ttl_pkg::CSR_HIGH_TRIP:  high_trip_ff  <= csr_wdata[ttl_pkg::THR_W-1:0];
            ttl_pkg::CSR_MID_CLEAR:  mid_clear_ff  <= csr_wdata[ttl_pkg::THR_W-1:0];
            ttl_pkg::CSR_HIGH_CLEAR: high_clear_ff <= csr_wdata[ttl_pkg::THR_W-1:0];
            ttl_pkg::CSR_LOW_CAP:    low_cap_ff    <= csr_wdata;
            ttl_pkg::CSR_MID_CAP:    mid_cap_ff    <= csr_wdata;
            ttl_pkg::CSR_HIGH_CAP:   high_cap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_q_ff <= req_data;
      end
   end

   // throttle decision on the registered request
   always_comb begin
      temp     = req_q_ff.temperature;
      rejected = !req_q_ff.read_ok || (temp > ttl_pkg::TEMP_LIMIT);
      cleared  = 1'b0;

      saved_max_in = saved_max_ff;
      if (level_ff == ttl_pkg::LVL_NONE || saved_max_ff < req_q_ff.user_max_freq) begin
         saved_max_in = req_q_ff.user_max_freq;
      end

      level_in      = level_ff;
      active_cap_in = active_cap_ff;
      // rules in priority order
      if (temp >= 12'(low_trip_ff) && temp < 12'(mid_trip_ff)
          && level_ff == ttl_pkg::LVL_NONE) begin
         level_in      = ttl_pkg::LVL_LOW;
         active_cap_in = low_cap_ff;
      end else if (temp <= LOW_CLEAR && level_ff != ttl_pkg::LVL_NONE) begin
         cleared       = 1'b1;
         level_in      = ttl_pkg::LVL_NONE;
         active_cap_in = '0;
      end else if (temp >= 12'(mid_trip_ff) && temp < 12'(high_trip_ff)
                   && level_ff < ttl_pkg::LVL_MID) begin
         level_in      = ttl_pkg::LVL_MID;
         active_cap_in = mid_cap_ff;
      end else if (temp < 12'(mid_clear_ff) && level_ff > ttl_pkg::LVL_LOW) begin
         level_in      = ttl_pkg::LVL_LOW;
         active_cap_in = low_cap_ff;
      end else if (temp >= 12'(high_trip_ff) && level_ff < ttl_pkg::LVL_HIGH) begin
         level_in      = ttl_pkg::LVL_HIGH;
         active_cap_in = high_cap_ff;
      end else if (temp < 12'(high_clear_ff) && level_ff == ttl_pkg::LVL_HIGH) begin
         level_in      = ttl_pkg::LVL_MID;
         active_cap_in = mid_cap_ff;
      end

      // response
      rsp_q_in.sample_rejected = rejected;
      if (rejected) begin
         rsp_q_in.apply_freq     = 1'b0;
         rsp_q_in.new_max_freq   = '0;
         rsp_q_in.throttle_level = level_ff;
      end else begin
         rsp_q_in.throttle_level = level_in;
         if (cleared) begin
            rsp_q_in.apply_freq   = 1'b1;
            rsp_q_in.new_max_freq = saved_max_in;
         end else if (active_cap_in != '0) begin
            rsp_q_in.apply_freq   = 1'b1;
            rsp_q_in.new_max_freq = active_cap_in;
         end else begin
            rsp_q_in.apply_freq   = 1'b0;
            rsp_q_in.new_max_freq = '0;
         end
      end
   end

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= ttl_pkg::LVL_NONE;
         saved_max_ff  <= '0;
         active_cap_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff && !rejected) begin
            level_ff      <= level_in;
            saved_max_ff  <= saved_max_in;
            active_cap_ff <= active_cap_in;
         end
      end
      if (advance && req_valid_ff) begin
         rsp_q_ff <= rsp_q_in;
      end
   end

   // checks
   `TTL_ASSERT_NOW(a_level_matches, clock, reset, rsp_valid_ff,
      rsp_q_ff.throttle_level == level_ff, "response level differs from state")
   `TTL_ASSERT_NOW(a_none_no_cap, clock, reset, level_ff == ttl_pkg::LVL_NONE,
      active_cap_ff == '0, "cap held with no throttle level")
   `TTL_ASSERT_NOW(a_cap_applied, clock, reset,
      rsp_valid_ff && rsp_q_ff.apply_freq && rsp_q_ff.throttle_level != ttl_pkg::LVL_NONE,
      rsp_q_ff.new_max_freq == active_cap_ff, "applied frequency is not the active cap")
   `TTL_ASSERT_NEXT(a_pipe_moves, clock, reset, req_valid_ff && !rsp_valid_ff,
      rsp_valid_ff, "request did not move to response register")

endmodule
